>>> rtl/core/colored_line_run_length_hints_assert.svh
// Assertion macros for the run-length hint encoder modules.
`ifndef COLORED_LINE_RUN_LENGTH_HINTS_ASSERT_SVH
`define COLORED_LINE_RUN_LENGTH_HINTS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clk edge outside of reset.
`define CLRH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside of reset.
`define CLRH_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define CLRH_ASSERT(label, prop, msg)
`define CLRH_NEVER(label, cond, msg)

`endif

`endif

>>> rtl/core/clrh_pkg.sv
// Shared types, constants and helper functions of the run-length hint encoder.
package clrh_pkg;

    localparam int CELL_WORD_BITS = 16;
    localparam int MAX_BITS_PER_CELL = 4;
    localparam int SHADE_W = 4;
    localparam int NUM_SHADES = (1 << MAX_BITS_PER_CELL) - 1;
    localparam int COUNT_W = 11;
    localparam int BPC_W = 3;
    localparam int SHIFT_W = 7;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [CELL_WORD_BITS-1:0] EMPTY_CELL = {CELL_WORD_BITS{1'b1}};

    // Configuration register indexes.
    localparam logic CFG_BITS_PER_CELL = 1'b0;
    localparam logic CFG_LAYER_SELECT = 1'b1;

    // Kind of an output record.
    typedef enum logic [1:0] {
        KIND_RUN     = 2'd0,
        KIND_TOTAL   = 2'd1,
        KIND_CHANGES = 2'd2
    } clrh_kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_mid;
        logic load_eolrun;
        logic load_total;
        logic load_changes;
        logic last;
        logic clear_line;
    } clrh_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mid_emit;
        logic eol;
        logic eol_clue;
        logic multi;
        logic total_last;
        logic out_free;
    } clrh_status_t;

    // Saturating increment of a count.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        logic [COUNT_W-1:0] r;
        begin
            if (v == COUNT_MAX)
                r = v;
            else
                r = v + COUNT_W'(1);
            return r;
        end
    endfunction

endpackage

>>> rtl/core/clrh_ctrl.sv
// Controller state machine that sequences cell intake and record emission.
`include "colored_line_run_length_hints_assert.svh"

module clrh_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  clrh_pkg::clrh_status_t status,
    output clrh_pkg::clrh_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MID,
        S_EOLRUN,
        S_TOTAL,
        S_CHANGES
    } state_t;

    state_t state_reg, state_next;
    logic   eol_reg, eol_next;
    logic   eol_clue_reg, eol_clue_next;
    logic   multi_reg, multi_next;
    logic [3:0] loads;
    logic   at_end;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        eol_next = eol_reg;
        eol_clue_next = eol_clue_reg;
        multi_next = multi_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    eol_next = status.eol;
                    eol_clue_next = status.eol_clue;
                    multi_next = status.multi;
                    if (status.mid_emit)
                        state_next = S_MID;
                    else if (status.eol)
                    begin
                        if (status.eol_clue)
                            state_next = S_EOLRUN;
                        else if (status.multi)
                            state_next = S_TOTAL;
                        else
                            cmd.clear_line = 1'b1;
                    end
                end
            end
            S_MID:
            begin
                if (status.out_free)
                begin
                    cmd.load_mid = 1'b1;
                    cmd.last = eol_reg && !eol_clue_reg && !multi_reg;
                    if (eol_reg && eol_clue_reg)
                        state_next = S_EOLRUN;
                    else if (eol_reg && multi_reg)
                        state_next = S_TOTAL;
                    else
                    begin
                        cmd.clear_line = eol_reg;
                        state_next = S_IDLE;
                    end
                end
            end
            S_EOLRUN:
            begin
                if (status.out_free)
                begin
                    cmd.load_eolrun = 1'b1;
                    cmd.last = !multi_reg;
                    if (multi_reg)
                        state_next = S_TOTAL;
                    else
                    begin
                        cmd.clear_line = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_TOTAL:
            begin
                if (status.out_free)
                begin
                    cmd.load_total = 1'b1;
                    if (status.total_last)
                        state_next = S_CHANGES;
                end
            end
            S_CHANGES:
            begin
                if (status.out_free)
                begin
                    cmd.load_changes = 1'b1;
                    cmd.last = 1'b1;
                    cmd.clear_line = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and latched line-end flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            eol_reg <= 1'b0;
            eol_clue_reg <= 1'b0;
            multi_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eol_reg <= eol_next;
            eol_clue_reg <= eol_clue_next;
            multi_reg <= multi_next;
        end
    end

    // Record loads and line-end conditions seen by the checks below.
    assign loads = {cmd.load_mid, cmd.load_eolrun, cmd.load_total, cmd.load_changes};
    assign at_end = cmd.last || (cmd.accept && status.eol);

    // At most one record is loaded per cycle, and never into a full output stage.
    `CLRH_ASSERT(a_one_load, $onehot0(loads), "more than one record loaded in a cycle")
    `CLRH_NEVER(a_load_when_full, (|loads) && !status.out_free, "record loaded while output is full")
    // The line state is cleared only at a line end.
    `CLRH_ASSERT(a_clear_at_end, cmd.clear_line |-> at_end, "line cleared away from a line end")
    // After the shade-change record the block is ready for the next cell.
    `CLRH_ASSERT(a_changes_done, cmd.load_changes |=> s_tready, "no intake after last record")

endmodule

>>> rtl/core/clrh_datapath.sv
// Datapath: shade extraction, run and histogram state, record output stage.
module clrh_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_addr,
    input  logic [clrh_pkg::SHADE_W-1:0]            cfg_data,
    input  logic [clrh_pkg::CELL_WORD_BITS-1:0]     cell_word,
    input  logic                                    end_of_line,
    input  clrh_pkg::clrh_cmd_t                     cmd,
    output clrh_pkg::clrh_status_t                  status,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output clrh_pkg::clrh_kind_t                    record_kind,
    output logic [clrh_pkg::SHADE_W-1:0]            shade,
    output logic [clrh_pkg::COUNT_W-1:0]            count,
    output logic                                    last_of_line
);

    localparam int SW = clrh_pkg::SHADE_W;
    localparam int CW = clrh_pkg::COUNT_W;
    localparam int NS = clrh_pkg::NUM_SHADES;
    localparam int WB = clrh_pkg::CELL_WORD_BITS;

    // Configuration registers.
    logic [clrh_pkg::BPC_W-1:0] bpc_reg;
    logic [SW-1:0]              layer_reg;

    // Line state.
    logic [CW-1:0] run_length_reg, run_length_next;
    logic [SW-1:0] run_shade_reg, run_shade_next;
    logic          run_valid_reg, run_valid_next;
    logic          any_run_reg, any_run_next;
    logic [CW-1:0] totals_reg [NS];
    logic [CW-1:0] totals_next [NS];
    logic [CW-1:0] changes_reg, changes_next;
    logic [SW-1:0] prev_shade_reg, prev_shade_next;
    logic          prev_valid_reg, prev_valid_next;
    logic [SW-1:0] tot_idx_reg, tot_idx_next;

    // Mid-line run clue captured at intake.
    logic [SW-1:0] mid_shade_reg, mid_shade_next;
    logic [CW-1:0] mid_count_reg, mid_count_next;

    // Output stage.
    logic                 out_valid_reg;
    clrh_pkg::clrh_kind_t kind_reg, kind_next;
    logic [SW-1:0]        oshade_reg, oshade_next;
    logic [CW-1:0]        ocount_reg, ocount_next;
    logic                 olast_reg, olast_next;

    logic [clrh_pkg::BPC_W-1:0]   eff_bpc;
    logic [SW-1:0]                top_shade;
    logic [clrh_pkg::SHIFT_W-1:0] shift;
    logic [WB-1:0]                shifted;
    logic [SW-1:0]                s;
    logic                         rv1;
    logic [SW-1:0]                rs1;
    logic                         mid_emit;
    logic                         eol_clue;
    logic                         load_any;

    // Effective field width and the highest shade it can hold.
    always_comb
    begin
        if (bpc_reg == '0)
            eff_bpc = clrh_pkg::BPC_W'(1);
        else if (bpc_reg > clrh_pkg::BPC_W'(clrh_pkg::MAX_BITS_PER_CELL))
            eff_bpc = clrh_pkg::BPC_W'(clrh_pkg::MAX_BITS_PER_CELL);
        else
            eff_bpc = bpc_reg;
        top_shade = SW'((5'd1 << eff_bpc) - 5'd1);
    end

    // Shade of the incoming cell.
    always_comb
    begin
        shift = clrh_pkg::SHIFT_W'(layer_reg) * clrh_pkg::SHIFT_W'(eff_bpc);
        shifted = cell_word >> shift[$clog2(WB)-1:0];
        if (cell_word == clrh_pkg::EMPTY_CELL || shift >= clrh_pkg::SHIFT_W'(WB))
            s = '0;
        else
            s = shifted[SW-1:0] & top_shade;
    end

    // Run state as the incoming cell would leave it. A run stays open exactly
    // when the cell is shaded, so the line-end clue follows from the shade.
    always_comb
    begin
        rv1 = run_valid_reg || (s != '0);
        rs1 = (!run_valid_reg && s != '0) ? s : run_shade_reg;
        mid_emit = !(rv1 && s == rs1) && (run_length_reg != '0);
        eol_clue = !(any_run_reg || mid_emit) || (s != '0);
    end

    // Run tracking, histogram and change count for one cell, total index step and line clear.
    always_comb
    begin
        run_length_next = run_length_reg;
        run_shade_next = run_shade_reg;
        run_valid_next = run_valid_reg;
        any_run_next = any_run_reg;
        changes_next = changes_reg;
        prev_shade_next = prev_shade_reg;
        prev_valid_next = prev_valid_reg;
        mid_shade_next = mid_shade_reg;
        mid_count_next = mid_count_reg;
        tot_idx_next = tot_idx_reg;
        for (int i = 0; i < NS; i++)
            totals_next[i] = totals_reg[i];

        if (cmd.accept)
        begin
            run_valid_next = rv1;
            run_shade_next = rs1;
            if (rv1 && s == rs1)
                run_length_next = clrh_pkg::sat_inc(run_length_reg);
            else if (mid_emit)
            begin
                mid_shade_next = rs1;
                mid_count_next = run_length_reg;
                any_run_next = 1'b1;
                if (s == '0)
                begin
                    run_length_next = '0;
                    run_shade_next = '0;
                    run_valid_next = 1'b0;
                end
                else
                begin
                    run_length_next = CW'(1);
                    run_shade_next = s;
                    run_valid_next = 1'b1;
                end
            end

            if (s != '0)
            begin
                for (int i = 0; i < NS; i++)
                begin
                    if (s == SW'(i + 1))
                        totals_next[i] = clrh_pkg::sat_inc(totals_reg[i]);
                end
                prev_valid_next = 1'b1;
                prev_shade_next = s;
                if (prev_valid_reg && prev_shade_reg != s)
                    changes_next = clrh_pkg::sat_inc(changes_reg);
            end
        end

        if (cmd.load_total)
            tot_idx_next = tot_idx_reg + SW'(1);

        if (cmd.clear_line)
        begin
            run_length_next = '0;
            run_shade_next = '0;
            run_valid_next = 1'b0;
            any_run_next = 1'b0;
            changes_next = CW'(1);
            prev_shade_next = '0;
            prev_valid_next = 1'b0;
            tot_idx_next = SW'(1);
            for (int i = 0; i < NS; i++)
                totals_next[i] = '0;
        end
    end

    // Status toward the controller.
    always_comb
    begin
        status.mid_emit = mid_emit;
        status.eol = end_of_line;
        status.eol_clue = eol_clue;
        status.multi = (eff_bpc > clrh_pkg::BPC_W'(1));
        status.total_last = (tot_idx_reg == top_shade);
        status.out_free = !out_valid_reg || m_tready;
    end

    // Record selection for the output stage.
    always_comb
    begin
        load_any = cmd.load_mid || cmd.load_eolrun || cmd.load_total || cmd.load_changes;
        kind_next = kind_reg;
        oshade_next = oshade_reg;
        ocount_next = ocount_reg;
        olast_next = olast_reg;
        if (cmd.load_mid)
        begin
            kind_next = clrh_pkg::KIND_RUN;
            oshade_next = mid_shade_reg;
            ocount_next = mid_count_reg;
        end
        else if (cmd.load_eolrun)
        begin
            kind_next = clrh_pkg::KIND_RUN;
            oshade_next = run_valid_reg ? run_shade_reg : '0;
            ocount_next = run_length_reg;
        end
        else if (cmd.load_total)
        begin
            kind_next = clrh_pkg::KIND_TOTAL;
            oshade_next = tot_idx_reg;
            ocount_next = totals_reg[SW'(tot_idx_reg - SW'(1))];
        end
        else if (cmd.load_changes)
        begin
            kind_next = clrh_pkg::KIND_CHANGES;
            oshade_next = '0;
            ocount_next = changes_reg;
        end
        if (load_any)
            olast_next = cmd.last;
    end

    // Control registers, configuration and line state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpc_reg <= clrh_pkg::BPC_W'(1);
            layer_reg <= '0;
            run_length_reg <= '0;
            run_shade_reg <= '0;
            run_valid_reg <= 1'b0;
            any_run_reg <= 1'b0;
            changes_reg <= CW'(1);
            prev_shade_reg <= '0;
            prev_valid_reg <= 1'b0;
            tot_idx_reg <= SW'(1);
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NS; i++)
                totals_reg[i] <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_addr)
                    clrh_pkg::CFG_BITS_PER_CELL: bpc_reg <= cfg_data[clrh_pkg::BPC_W-1:0];
                    clrh_pkg::CFG_LAYER_SELECT:  layer_reg <= cfg_data;
                    default:                     layer_reg <= layer_reg;
                endcase
            end
            run_length_reg <= run_length_next;
            run_shade_reg <= run_shade_next;
            run_valid_reg <= run_valid_next;
            any_run_reg <= any_run_next;
            changes_reg <= changes_next;
            prev_shade_reg <= prev_shade_next;
            prev_valid_reg <= prev_valid_next;
            tot_idx_reg <= tot_idx_next;
            for (int i = 0; i < NS; i++)
                totals_reg[i] <= totals_next[i];
            if (load_any)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        mid_shade_reg <= mid_shade_next;
        mid_count_reg <= mid_count_next;
        kind_reg <= kind_next;
        oshade_reg <= oshade_next;
        ocount_reg <= ocount_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = out_valid_reg;
    assign record_kind = kind_reg;
    assign shade = oshade_reg;
    assign count = ocount_reg;
    assign last_of_line = olast_reg;

endmodule

>>> rtl/core/colored_line_run_length_hints.sv
// Top level of the colored run-length hint encoder for one grid line.
//
// Channel   Direction  Word
// s_*       in         cell word (tdata), end of line (tlast)
// m_*       out        record kind (tuser), shade and count (tdata), last record (tlast)
// cfg_*     in         register index and write data
//
// A cell that yields no record leaves intake open, so such cells stream at one per
// cycle while no record is pending. Each record passes the single output register.
// With b effective bits per cell above one, a line end adds 2^b - 1 totals and the
// change count after up to two run clues, so one cell yields at most 18 records.
// A stall on m_tready holds the current record; intake stays closed until the last cell's
// records are all loaded. Reset restores one bit per cell, layer 0 and a cleared line.
module colored_line_run_length_hints (
    input  logic        clk,
    input  logic        rst_n,
    // Cell stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] cell_word
    input  logic        s_tlast,   // end_of_line
    // Record stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] shade, [14:4] count, [15] zero
    output logic [1:0]  m_tuser,   // [1:0] record_kind
    output logic        m_tlast,   // last_of_line
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_data
);

    clrh_pkg::clrh_cmd_t    cmd;
    clrh_pkg::clrh_status_t status;
    clrh_pkg::clrh_kind_t   record_kind;
    logic [clrh_pkg::SHADE_W-1:0] shade;
    logic [clrh_pkg::COUNT_W-1:0] count;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    clrh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    clrh_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data),
        .cell_word    (s_tdata),
        .end_of_line  (s_tlast),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .record_kind  (record_kind),
        .shade        (shade),
        .count        (count),
        .last_of_line (m_tlast)
    );

    // Pack the record word.
    assign m_tdata = {1'b0, count, shade};
    assign m_tuser = record_kind;

endmodule
